[rtl/amou_pkg.sv]
// Shared types and constants for the RV32A atomic memory operation unit.
// Used by amou_alu, amou_ctrl and atomic_memory_op_unit; depends on nothing.

package amou_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned REG_W = 5;
  localparam int unsigned OP_W = 5;

  // Byte strobe of a full-word access: all four bytes.
  localparam logic [3:0] FULL_STROBE = 4'b1111;

  localparam logic [OP_W-1:0] OP_ADD  = 5'b00000;
  localparam logic [OP_W-1:0] OP_SWAP = 5'b00001;
  localparam logic [OP_W-1:0] OP_LR   = 5'b00010;
  localparam logic [OP_W-1:0] OP_SC   = 5'b00011;
  localparam logic [OP_W-1:0] OP_XOR  = 5'b00100;
  localparam logic [OP_W-1:0] OP_OR   = 5'b01000;
  localparam logic [OP_W-1:0] OP_AND  = 5'b01100;
  localparam logic [OP_W-1:0] OP_MIN  = 5'b10000;
  localparam logic [OP_W-1:0] OP_MAX  = 5'b10100;
  localparam logic [OP_W-1:0] OP_MINU = 5'b11000;
  localparam logic [OP_W-1:0] OP_MAXU = 5'b11100;

  localparam logic REQ_ISSUE    = 1'b0;
  localparam logic REQ_RESPONSE = 1'b1;

  typedef enum logic [1:0] {
    STAGE_IDLE  = 2'd0,
    STAGE_READ  = 2'd1,
    STAGE_WRITE = 2'd2
  } stage_t;

  typedef struct packed {
    logic            req_type;
    logic [OP_W-1:0] op_code;
    logic [REG_W-1:0] dest_reg;
    logic [XLEN-1:0] address;
    logic [XLEN-1:0] source_value;
    logic [XLEN-1:0] mem_data;
    logic            store_ready;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             mem_req_valid;
    logic             mem_req_store;
    logic [XLEN-1:0]  mem_req_addr;
    logic [XLEN-1:0]  mem_req_data;
    logic             wb_valid;
    logic [REG_W-1:0] wb_reg;
    logic [XLEN-1:0]  wb_value;
    logic             busy_res;
    logic             error;
  } out_item_t;

  function automatic logic is_rmw(input logic [OP_W-1:0] op);
    logic r;
    case (op) inside
      OP_ADD, OP_SWAP, OP_XOR, OP_OR, OP_AND,
      OP_MIN, OP_MAX, OP_MINU, OP_MAXU: r = 1'b1;
      default:                          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/atomic_memory_op_unit.sv]
// RV32A atomic memory operation unit, top level.
// Each item passes an input register and then a result register; throughput 1
// item per cycle while result_ready holds, set by the single pass through the
// sequencer between the two registers.
// Reset (synchronous, rst high) empties both registers, idles the stage and
// drops the reservation. Depends on amou_pkg and amou_ctrl.

module atomic_memory_op_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  amou_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output amou_pkg::out_item_t result
);

  logic                in_valid_q;
  amou_pkg::in_item_t  in_q;
  amou_pkg::out_item_t res_comb;
  logic                fire;

  // advance when the held item can move into a free or draining result slot
  assign fire       = in_valid_q && (!result_valid || result_ready);
  assign item_ready = !in_valid_q || fire;

  amou_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_q),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        in_valid_q <= item_valid;
      end
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
    if (fire) begin
      result <= res_comb;
    end
  end

endmodule

[rtl/amou_alu.sv]
// Read-modify-write combine unit: merges the old memory word with the operand.
// Depends on amou_pkg for opcodes and widths.

module amou_alu (
  input  logic [amou_pkg::OP_W-1:0] op,
  input  logic [amou_pkg::XLEN-1:0] old_word,
  input  logic [amou_pkg::XLEN-1:0] operand,
  output logic [amou_pkg::XLEN-1:0] new_word
);

  logic lt_signed;
  logic lt_unsigned;

  assign lt_signed   = $signed(old_word) < $signed(operand);
  assign lt_unsigned = old_word < operand;

  always_comb begin
    unique case (op)
      amou_pkg::OP_ADD:  new_word = old_word + operand;
      amou_pkg::OP_SWAP: new_word = operand;
      amou_pkg::OP_XOR:  new_word = old_word ^ operand;
      amou_pkg::OP_OR:   new_word = old_word | operand;
      amou_pkg::OP_AND:  new_word = old_word & operand;
      amou_pkg::OP_MIN:  new_word = lt_signed ? old_word : operand;
      amou_pkg::OP_MAX:  new_word = lt_signed ? operand : old_word;
      amou_pkg::OP_MINU: new_word = lt_unsigned ? old_word : operand;
      // maxu, and anything that never reaches the write path
      default:           new_word = lt_unsigned ? operand : old_word;
    endcase
  end

endmodule

[rtl/amou_ctrl.sv]
// Operation sequencer: stage, pending operation and LR reservation state,
// plus the per-item decision logic. Depends on amou_pkg and amou_alu.

module amou_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  amou_pkg::in_item_t  item,
  output amou_pkg::out_item_t res
);

  amou_pkg::stage_t                 stage, stage_next;
  logic [amou_pkg::OP_W-1:0]        pending_op, pending_op_next;
  logic [amou_pkg::REG_W-1:0]       pending_dest, pending_dest_next;
  logic [amou_pkg::XLEN-1:0]        pending_addr, pending_addr_next;
  logic [amou_pkg::XLEN-1:0]        pending_operand, pending_operand_next;
  logic                             reservation_valid, reservation_valid_next;
  logic [amou_pkg::XLEN-1:0]        reservation_addr, reservation_addr_next;

  logic [amou_pkg::XLEN-1:0] store_word;
  logic                      idle;
  logic                      sc_ok;

  amou_alu u_alu (
    .op       (pending_op),
    .old_word (item.mem_data),
    .operand  (pending_operand),
    .new_word (store_word)
  );

  assign idle  = (stage != amou_pkg::STAGE_READ) && (stage != amou_pkg::STAGE_WRITE);
  assign sc_ok = reservation_valid && (reservation_addr == item.address);

  always_comb begin
    stage_next             = stage;
    pending_op_next        = pending_op;
    pending_dest_next      = pending_dest;
    pending_addr_next      = pending_addr;
    pending_operand_next   = pending_operand;
    reservation_valid_next = reservation_valid;
    reservation_addr_next  = reservation_addr;
    res                    = '0;
    res.accepted           = 1'b1;

    if (item.req_type == amou_pkg::REQ_ISSUE) begin
      if (!idle) begin
        res.accepted = 1'b0;
      end else if (item.op_code == amou_pkg::OP_SC) begin
        if (sc_ok && !item.store_ready) begin
          res.accepted = 1'b0;
        end else if (!sc_ok) begin
          // fail at once, no memory traffic
          res.wb_valid           = 1'b1;
          res.wb_reg             = item.dest_reg;
          res.wb_value           = amou_pkg::XLEN'(1);
          reservation_valid_next = 1'b0;
          pending_op_next        = item.op_code;
          pending_dest_next      = item.dest_reg;
          stage_next             = amou_pkg::STAGE_IDLE;
        end else begin
          res.mem_req_valid = 1'b1;
          res.mem_req_store = 1'b1;
          res.mem_req_addr  = item.address;
          res.mem_req_data  = item.source_value;
          pending_op_next   = item.op_code;
          pending_dest_next = item.dest_reg;
          stage_next        = amou_pkg::STAGE_WRITE;
        end
      end else if (item.op_code == amou_pkg::OP_LR || amou_pkg::is_rmw(item.op_code)) begin
        if (!item.store_ready) begin
          res.accepted = 1'b0;
        end else begin
          res.mem_req_valid = 1'b1;
          res.mem_req_addr  = item.address;
          pending_op_next   = item.op_code;
          pending_dest_next = item.dest_reg;
          pending_addr_next = item.address;
          if (item.op_code != amou_pkg::OP_LR) begin
            pending_operand_next = item.source_value;
          end
          stage_next = amou_pkg::STAGE_READ;
        end
      end else begin
        res.error = 1'b1;
      end
    end else begin
      if (idle) begin
        res.error = 1'b1;
      end else if (pending_op == amou_pkg::OP_LR) begin
        if (stage == amou_pkg::STAGE_READ) begin
          reservation_valid_next = 1'b1;
          reservation_addr_next  = pending_addr;
          res.wb_valid           = 1'b1;
          res.wb_reg             = pending_dest;
          res.wb_value           = item.mem_data;
          stage_next             = amou_pkg::STAGE_IDLE;
        end else begin
          res.error = 1'b1;
        end
      end else if (pending_op == amou_pkg::OP_SC) begin
        if (stage == amou_pkg::STAGE_WRITE) begin
          res.wb_valid           = 1'b1;
          res.wb_reg             = pending_dest;
          reservation_valid_next = 1'b0;
          stage_next             = amou_pkg::STAGE_IDLE;
        end else begin
          res.error = 1'b1;
        end
      end else if (amou_pkg::is_rmw(pending_op)) begin
        if (stage == amou_pkg::STAGE_READ) begin
          // the load data goes back to the register and the merged word out
          if (!item.store_ready) begin
            res.accepted = 1'b0;
          end else begin
            res.wb_valid      = 1'b1;
            res.wb_reg        = pending_dest;
            res.wb_value      = item.mem_data;
            res.mem_req_valid = 1'b1;
            res.mem_req_store = 1'b1;
            res.mem_req_addr  = pending_addr;
            res.mem_req_data  = store_word;
            stage_next        = amou_pkg::STAGE_WRITE;
          end
        end else begin
          stage_next = amou_pkg::STAGE_IDLE;
        end
      end else begin
        res.error = 1'b1;
      end
    end

    res.busy_res = (stage_next == amou_pkg::STAGE_READ) ||
                   (stage_next == amou_pkg::STAGE_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage             <= amou_pkg::STAGE_IDLE;
      pending_op        <= '0;
      pending_dest      <= '0;
      pending_addr      <= '0;
      pending_operand   <= '0;
      reservation_valid <= 1'b0;
      reservation_addr  <= '0;
    end else if (fire) begin
      stage             <= stage_next;
      pending_op        <= pending_op_next;
      pending_dest      <= pending_dest_next;
      pending_addr      <= pending_addr_next;
      pending_operand   <= pending_operand_next;
      reservation_valid <= reservation_valid_next;
      reservation_addr  <= reservation_addr_next;
    end
  end

endmodule
